@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the contact unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle
`define BSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the next cycle
`define BSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Box-sphere contact package
// Widths, payload types and saturating helpers shared by the pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int CW  = 32;          // coordinate width
   localparam int FB  = 16;          // fraction bits
   localparam int NW  = 18;          // normal component width
   localparam int RW  = CW - 1;      // radius width
   localparam int SQW = 2 * CW;      // squared distance width
   localparam int DVW = CW + FB + 1; // normal dividend width
   localparam int QW  = FB + 1;      // normal quotient width
   localparam int EW  = CW + 4;      // headroom width for halving and saturation

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [NW-1:0] norm_type;

   localparam norm_type NORM_ONE = norm_type'(1 << FB);

   typedef struct packed {
      coord_type       box_x;
      coord_type       box_y;
      coord_type       box_z;
      coord_type       box_width;
      coord_type       box_height;
      coord_type       box_depth;
      coord_type       sphere_x;
      coord_type       sphere_y;
      coord_type       sphere_z;
      logic [RW-1:0]   radius;
   } bsc_req_type;

   typedef struct packed {
      logic      hit;
      norm_type  normal_x;
      norm_type  normal_y;
      norm_type  normal_z;
      coord_type depth;
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
   } bsc_rsp_type;

   // Result so far plus what the outside case still needs
   typedef struct packed {
      bsc_rsp_type          res;
      logic                 done;
      logic [2:0]           dneg;
      logic [2:0][CW-1:0]   mag;
      logic [CW-1:0]        r2;
   } bsc_side_type;

   function automatic coord_type sat_coord(input logic signed [EW-1:0] v);
      logic signed [EW-1:0] hi_lim;
      logic signed [EW-1:0] lo_lim;
      hi_lim = EW'({1'b0, {(CW-1){1'b1}}});
      lo_lim = ~hi_lim;
      if (v > hi_lim) begin
         return hi_lim[CW-1:0];
      end else if (v < lo_lim) begin
         return lo_lim[CW-1:0];
      end
      return v[CW-1:0];
   endfunction

   // Doubled units back to single: nearest, ties toward +inf
   function automatic logic signed [EW-1:0] halve(input logic signed [EW-1:0] v);
      return (v + EW'(1)) >>> 1;
   endfunction

endpackage

@@ rtl/bsc_front.sv @@
// ----------------------------------------------------------------------------
// Contact front end
// Six stages: clamp, offsets, squares, sum, overlap test and inside result.
// ----------------------------------------------------------------------------
module bsc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  bsc_pkg::bsc_req_type      in_req,
   output logic                      out_valid,
   output logic [bsc_pkg::SQW-1:0]   out_sum,
   output bsc_pkg::bsc_side_type     out_side
);
   import bsc_pkg::*;

   localparam int XW = CW + 2;
   localparam int PW = CW + 3;

   coord_type box [3];
   coord_type size [3];
   coord_type sph [3];

   assign box[0]  = in_req.box_x;
   assign box[1]  = in_req.box_y;
   assign box[2]  = in_req.box_z;
   assign size[0] = in_req.box_width;
   assign size[1] = in_req.box_height;
   assign size[2] = in_req.box_depth;
   assign sph[0]  = in_req.sphere_x;
   assign sph[1]  = in_req.sphere_y;
   assign sph[2]  = in_req.sphere_z;

   // Stage 1 registers
   logic                 s1_v_ff,  s1_neg_ff, s1_neg_in;
   logic signed [XW-1:0] s1_s_ff [3], s1_lo_ff [3], s1_hi_ff [3], s1_off_ff [3];
   logic signed [XW-1:0] s1_s_in [3], s1_lo_in [3], s1_hi_in [3], s1_off_in [3];
   coord_type            s1_w_ff [3], s1_sph_ff [3];
   logic [CW-1:0]        s1_r2_ff, s1_r2_in;
   logic signed [XW-1:0] b_dbl [3], w_ext [3];

   // Stage 2 registers
   logic                 s2_v_ff, s2_neg_ff;
   logic signed [XW-1:0] s2_s_ff [3], s2_cl_ff [3], s2_cl_in [3];
   logic signed [PW-1:0] s2_p_ff [3], s2_p_in [3];
   logic signed [XW-1:0] abs_off [3];
   logic [2:0]           s2_offneg_ff, s2_offneg_in;
   coord_type            s2_sph_ff [3];
   logic [CW-1:0]        s2_r2_ff;

   // Stage 3 registers
   logic                 s3_v_ff, s3_neg_ff;
   logic signed [PW-1:0] diff [3];
   logic [PW-1:0]        mag_full [3];
   logic [CW-1:0]        s3_mag_ff [3], s3_mag_in [3];
   logic [2:0]           s3_over_ff, s3_over_in, s3_dneg_ff, s3_dneg_in;
   logic [2:0]           s3_zero_ff, s3_zero_in;
   logic [1:0]           s3_ax_ff, s3_ax_in;
   logic signed [PW-1:0] s3_pax_ff, s3_pax_in;
   logic                 s3_axneg_ff, s3_axneg_in;
   coord_type            s3_pt_ff [3], s3_pt_in [3], s3_sph_ff [3];
   logic [CW-1:0]        s3_r2_ff;

   // Stage 4 registers
   logic                 s4_v_ff, s4_neg_ff, s4_over_ff, s4_inside_ff;
   logic [SQW-1:0]       s4_sq_ff [3], s4_lim_ff;
   bsc_rsp_type          s4_inres_ff, s4_inres_in;
   logic [2:0]           s4_dneg_ff;
   logic [CW-1:0]        s4_mag_ff [3];
   coord_type            s4_pt_ff [3];
   logic [CW-1:0]        s4_r2_ff;

   // Stage 5 registers
   logic                 s5_v_ff, s5_neg_ff, s5_over_ff, s5_inside_ff;
   logic [SQW+1:0]       s5_sum_ff, s5_sum_in;
   logic [SQW-1:0]       s5_lim_ff;
   bsc_rsp_type          s5_inres_ff;
   logic [2:0]           s5_dneg_ff;
   logic [CW-1:0]        s5_mag_ff [3];
   coord_type            s5_pt_ff [3];
   logic [CW-1:0]        s5_r2_ff;

   // Stage 6 registers
   logic                 s6_v_ff;
   logic [SQW-1:0]       s6_sum_ff;
   bsc_side_type         s6_side_ff, s6_side_in;
   logic                 hit6;
   bsc_rsp_type          outres6;

   // Stage 1: doubled coordinates, box extent and center offset
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_dbl[i]     = {box[i][CW-1], box[i], 1'b0};
         s1_s_in[i]   = {sph[i][CW-1], sph[i], 1'b0};
         w_ext[i]     = XW'(size[i]);
         s1_lo_in[i]  = b_dbl[i] - w_ext[i];
         s1_hi_in[i]  = b_dbl[i] + w_ext[i];
         s1_off_in[i] = s1_s_in[i] - b_dbl[i];
      end
      s1_neg_in = size[0][CW-1] | size[1][CW-1] | size[2][CW-1];
      s1_r2_in  = {in_req.radius, 1'b0};
   end

   // Stage 2: clamp the center to the box and get face depths
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s1_s_ff[i] < s1_lo_ff[i]) begin
            s2_cl_in[i] = s1_lo_ff[i];
         end else if (s1_s_ff[i] > s1_hi_ff[i]) begin
            s2_cl_in[i] = s1_hi_ff[i];
         end else begin
            s2_cl_in[i] = s1_s_ff[i];
         end
         abs_off[i]      = s1_off_ff[i][XW-1] ? -s1_off_ff[i] : s1_off_ff[i];
         s2_p_in[i]      = PW'(s1_w_ff[i]) - PW'(abs_off[i]);
         s2_offneg_in[i] = s1_off_ff[i][XW-1];
      end
   end

   // Stage 3: offset from clamped point, magnitude, least-depth axis
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff[i]        = PW'(s2_s_ff[i]) - PW'(s2_cl_ff[i]);
         s3_dneg_in[i]  = diff[i][PW-1];
         mag_full[i]    = s3_dneg_in[i] ? -diff[i] : diff[i];
         s3_mag_in[i]   = mag_full[i][CW-1:0];
         s3_over_in[i]  = mag_full[i] > PW'(s2_r2_ff);
         s3_zero_in[i]  = (diff[i] == '0);
         s3_pt_in[i]    = sat_coord(halve(EW'(s2_cl_ff[i])));
      end
      if (s2_p_ff[0] < s2_p_ff[1] && s2_p_ff[0] < s2_p_ff[2]) begin
         s3_ax_in = AXIS_X;
      end else if (s2_p_ff[1] < s2_p_ff[2] && s2_p_ff[1] < s2_p_ff[0]) begin
         s3_ax_in = AXIS_Y;
      end else begin
         s3_ax_in = AXIS_Z;
      end
      unique case (s3_ax_in)
         AXIS_X: begin
            s3_pax_in   = s2_p_ff[0];
            s3_axneg_in = s2_offneg_ff[0];
         end
         AXIS_Y: begin
            s3_pax_in   = s2_p_ff[1];
            s3_axneg_in = s2_offneg_ff[1];
         end
         default: begin
            s3_pax_in   = s2_p_ff[2];
            s3_axneg_in = s2_offneg_ff[2];
         end
      endcase
   end

   // Stage 4: result for a center inside the box
   always_comb begin
      s4_inres_in          = '0;
      s4_inres_in.hit      = 1'b1;
      s4_inres_in.depth    = sat_coord(halve(EW'(s3_pax_ff) + $signed({4'b0, s3_r2_ff})));
      s4_inres_in.point_x  = s3_sph_ff[0];
      s4_inres_in.point_y  = s3_sph_ff[1];
      s4_inres_in.point_z  = s3_sph_ff[2];
      unique case (s3_ax_ff)
         AXIS_X:  s4_inres_in.normal_x = s3_axneg_ff ? -NORM_ONE : NORM_ONE;
         AXIS_Y:  s4_inres_in.normal_y = s3_axneg_ff ? -NORM_ONE : NORM_ONE;
         default: s4_inres_in.normal_z = s3_axneg_ff ? -NORM_ONE : NORM_ONE;
      endcase
   end

   // Stage 5: squared distance
   assign s5_sum_in = (SQW+2)'(s4_sq_ff[0]) + (SQW+2)'(s4_sq_ff[1]) + (SQW+2)'(s4_sq_ff[2]);

   // Stage 6: overlap test and result selection
   always_comb begin
      hit6             = !s5_neg_ff && !s5_over_ff && (s5_sum_ff <= (SQW+2)'(s5_lim_ff));
      outres6          = '0;
      outres6.hit      = 1'b1;
      outres6.point_x  = s5_pt_ff[0];
      outres6.point_y  = s5_pt_ff[1];
      outres6.point_z  = s5_pt_ff[2];
      s6_side_in.res   = !hit6 ? '0 : (s5_inside_ff ? s5_inres_ff : outres6);
      s6_side_in.done  = !hit6 || s5_inside_ff;
      s6_side_in.dneg  = s5_dneg_ff;
      for (int i = 0; i < 3; i++) begin
         s6_side_in.mag[i] = s5_mag_ff[i];
      end
      s6_side_in.r2    = s5_r2_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
      end
   end

   // Payload, advanced together with the valid bits
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s1_s_ff[i]   <= s1_s_in[i];
            s1_lo_ff[i]  <= s1_lo_in[i];
            s1_hi_ff[i]  <= s1_hi_in[i];
            s1_off_ff[i] <= s1_off_in[i];
            s1_w_ff[i]   <= size[i];
            s1_sph_ff[i] <= sph[i];
            s2_s_ff[i]   <= s1_s_ff[i];
            s2_cl_ff[i]  <= s2_cl_in[i];
            s2_p_ff[i]   <= s2_p_in[i];
            s2_sph_ff[i] <= s1_sph_ff[i];
            s3_mag_ff[i] <= s3_mag_in[i];
            s3_pt_ff[i]  <= s3_pt_in[i];
            s3_sph_ff[i] <= s2_sph_ff[i];
            s4_sq_ff[i]  <= s3_mag_ff[i] * s3_mag_ff[i];
            s4_mag_ff[i] <= s3_mag_ff[i];
            s4_pt_ff[i]  <= s3_pt_ff[i];
            s5_mag_ff[i] <= s4_mag_ff[i];
            s5_pt_ff[i]  <= s4_pt_ff[i];
         end
         s1_neg_ff    <= s1_neg_in;
         s1_r2_ff     <= s1_r2_in;
         s2_neg_ff    <= s1_neg_ff;
         s2_offneg_ff <= s2_offneg_in;
         s2_r2_ff     <= s1_r2_ff;
         s3_neg_ff    <= s2_neg_ff;
         s3_over_ff   <= s3_over_in;
         s3_dneg_ff   <= s3_dneg_in;
         s3_zero_ff   <= s3_zero_in;
         s3_ax_ff     <= s3_ax_in;
         s3_pax_ff    <= s3_pax_in;
         s3_axneg_ff  <= s3_axneg_in;
         s3_r2_ff     <= s2_r2_ff;
         s4_neg_ff    <= s3_neg_ff;
         s4_over_ff   <= |s3_over_ff;
         s4_inside_ff <= &s3_zero_ff;
         s4_lim_ff    <= s3_r2_ff * s3_r2_ff;
         s4_inres_ff  <= s4_inres_in;
         s4_dneg_ff   <= s3_dneg_ff;
         s4_r2_ff     <= s3_r2_ff;
         s5_neg_ff    <= s4_neg_ff;
         s5_over_ff   <= s4_over_ff;
         s5_inside_ff <= s4_inside_ff;
         s5_sum_ff    <= s5_sum_in;
         s5_lim_ff    <= s4_lim_ff;
         s5_inres_ff  <= s4_inres_ff;
         s5_dneg_ff   <= s4_dneg_ff;
         s5_r2_ff     <= s4_r2_ff;
         s6_sum_ff    <= s5_sum_ff[SQW-1:0];
         s6_side_ff   <= s6_side_in;
      end
   end

   assign out_valid = s6_v_ff;
   assign out_sum   = s6_sum_ff;
   assign out_side  = s6_side_ff;

endmodule

@@ rtl/bsc_sqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined square root
// One root bit per stage, then a rounding stage: nearest integer root.
// ----------------------------------------------------------------------------
module bsc_sqrt (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic [bsc_pkg::SQW-1:0] in_rad,
   input  bsc_pkg::bsc_side_type   in_side,
   output logic                    out_valid,
   output logic [bsc_pkg::CW:0]    out_len,
   output bsc_pkg::bsc_side_type   out_side
);
   import bsc_pkg::*;

   localparam int NS = SQW / 2;

   logic         v_ff [NS];
   logic [SQW-1:0] rad_ff [NS], rad_in [NS], src_rad [NS];
   logic [NS:0]    rem_ff [NS], rem_in [NS], src_rem [NS];
   logic [NS-1:0]  root_ff [NS], root_in [NS], src_root [NS];
   bsc_side_type   side_ff [NS], src_side [NS];
   logic           src_v [NS];
   logic [NS+2:0]  rem_sh [NS], trial [NS], rem_sub [NS];

   logic           rnd_v_ff;
   logic [NS:0]    len_ff, len_in;
   bsc_side_type   rnd_side_ff;

   // One root bit per stage
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         if (k == 0) begin
            src_v[k]    = in_valid;
            src_rad[k]  = in_rad;
            src_rem[k]  = '0;
            src_root[k] = '0;
            src_side[k] = in_side;
         end else begin
            src_v[k]    = v_ff[k-1];
            src_rad[k]  = rad_ff[k-1];
            src_rem[k]  = rem_ff[k-1];
            src_root[k] = root_ff[k-1];
            src_side[k] = side_ff[k-1];
         end
         rem_sh[k]  = {src_rem[k], src_rad[k][SQW-1 -: 2]};
         trial[k]   = {1'b0, src_root[k], 2'b01};
         rem_sub[k] = rem_sh[k] - trial[k];
         if (rem_sh[k] >= trial[k]) begin
            rem_in[k]  = rem_sub[k][NS:0];
            root_in[k] = {src_root[k][NS-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh[k][NS:0];
            root_in[k] = {src_root[k][NS-2:0], 1'b0};
         end
         rad_in[k] = src_rad[k] << 2;
      end
   end

   // Round up when the remainder exceeds the root
   assign len_in = (NS+1)'(root_ff[NS-1])
                 + (NS+1)'(rem_ff[NS-1] > (NS+1)'(root_ff[NS-1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= 1'b0;
         end
         rnd_v_ff <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < NS; k++) begin
            v_ff[k] <= src_v[k];
         end
         rnd_v_ff <= v_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NS; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= src_side[k];
         end
         len_ff      <= len_in;
         rnd_side_ff <= side_ff[NS-1];
      end
   end

   assign out_valid = rnd_v_ff;
   assign out_len   = len_ff;
   assign out_side  = rnd_side_ff;

endmodule

@@ rtl/bsc_div.sv @@
// ----------------------------------------------------------------------------
// Normal divider
// Three restoring divider lanes, one quotient bit per stage, plus the
// outside-case depth and the final result assembly.
// ----------------------------------------------------------------------------
module bsc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [bsc_pkg::CW:0]  in_len,
   input  bsc_pkg::bsc_side_type in_side,
   output logic                  out_valid,
   output bsc_pkg::bsc_rsp_type  out_rsp
);
   import bsc_pkg::*;

   localparam int LW = DVW + 1;

   // Preparation stage
   logic                  pre_v_ff;
   logic [2:0][DVW-1:0]   pre_dvd_ff, pre_dvd_in;
   logic [CW:0]           pre_len_ff;
   bsc_side_type          pre_side_ff, pre_side_in;

   // Quotient stages
   logic                  v_ff [QW], src_v [QW];
   logic [2:0][DVW-1:0]   rem_ff [QW], rem_in [QW], src_rem [QW];
   logic [2:0][QW-1:0]    q_ff [QW], q_in [QW], src_q [QW];
   logic [CW:0]           len_ff [QW], src_len [QW];
   bsc_side_type          side_ff [QW], src_side [QW];
   logic [LW-1:0]         dsr [QW];
   logic [2:0][LW-1:0]    rem_sub [QW];

   // Output stage
   logic                  fin_v_ff;
   bsc_rsp_type           fin_ff, fin_in;
   norm_type              qn [3];

   // Scale magnitudes, add half the divisor, and work out the depth
   always_comb begin
      pre_side_in = in_side;
      for (int i = 0; i < 3; i++) begin
         pre_dvd_in[i] = DVW'({in_side.mag[i], {FB{1'b0}}}) + DVW'(in_len >> 1);
      end
      if (!in_side.done) begin
         pre_side_in.res.depth =
            sat_coord(halve($signed({4'b0, in_side.r2}) - $signed({3'b0, in_len})));
      end
   end

   // One quotient bit per stage in each lane
   always_comb begin
      for (int j = 0; j < QW; j++) begin
         if (j == 0) begin
            src_v[j]    = pre_v_ff;
            src_rem[j]  = pre_dvd_ff;
            src_q[j]    = '0;
            src_len[j]  = pre_len_ff;
            src_side[j] = pre_side_ff;
         end else begin
            src_v[j]    = v_ff[j-1];
            src_rem[j]  = rem_ff[j-1];
            src_q[j]    = q_ff[j-1];
            src_len[j]  = len_ff[j-1];
            src_side[j] = side_ff[j-1];
         end
         dsr[j] = LW'(src_len[j]) << (QW - 1 - j);
         for (int i = 0; i < 3; i++) begin
            rem_sub[j][i] = LW'(src_rem[j][i]) - dsr[j];
            if (LW'(src_rem[j][i]) >= dsr[j]) begin
               rem_in[j][i] = rem_sub[j][i][DVW-1:0];
               q_in[j][i]   = {src_q[j][i][QW-2:0], 1'b1};
            end else begin
               rem_in[j][i] = src_rem[j][i];
               q_in[j][i]   = {src_q[j][i][QW-2:0], 1'b0};
            end
         end
      end
   end

   // Assemble the result: signed normals for the outside case
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qn[i] = side_ff[QW-1].dneg[i] ? -NW'(q_ff[QW-1][i]) : NW'(q_ff[QW-1][i]);
      end
      fin_in = side_ff[QW-1].res;
      if (!side_ff[QW-1].done) begin
         fin_in.normal_x = qn[0];
         fin_in.normal_y = qn[1];
         fin_in.normal_z = qn[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_v_ff <= 1'b0;
         for (int j = 0; j < QW; j++) begin
            v_ff[j] <= 1'b0;
         end
         fin_v_ff <= 1'b0;
      end else if (en) begin
         pre_v_ff <= in_valid;
         for (int j = 0; j < QW; j++) begin
            v_ff[j] <= src_v[j];
         end
         fin_v_ff <= v_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_dvd_ff  <= pre_dvd_in;
         pre_len_ff  <= in_len;
         pre_side_ff <= pre_side_in;
         for (int j = 0; j < QW; j++) begin
            rem_ff[j]  <= rem_in[j];
            q_ff[j]    <= q_in[j];
            len_ff[j]  <= src_len[j];
            side_ff[j] <= src_side[j];
         end
         fin_ff <= fin_in;
      end
   end

   assign out_valid = fin_v_ff;
   assign out_rsp   = fin_ff;

endmodule

@@ rtl/box_sphere_contact_unit.sv @@
// ----------------------------------------------------------------------------
// Box-sphere contact unit
// Axis-aligned box against sphere: overlap test, normal, depth and point.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake             | Payload
//  req_*    | in  | req_tvalid/req_tready | req_tdata: box, sizes, sphere, radius
//  rsp_*    | out | rsp_tvalid/rsp_tready | rsp_tdata: normal, depth, point;
//           |     |                       | rsp_tuser: hit
//
//  One request per cycle while the pipeline is not stalled; each response
//  passes through 6 front stages, 33 square-root stages, 19 divider
//  stages and the output slot.
//  Reset clears valid bits and the two-entry output buffer.
//  The pipeline stalls only when both output slots are full; one waiting
//  response never blocks a new request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_sphere_contact_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // box_x, box_y, box_z, box_width, box_height, box_depth,
   // sphere_x, sphere_y, sphere_z (32 each), radius (31), pad (1)
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x, normal_y, normal_z (18 each), depth, point_x, point_y,
   // point_z (32 each), pad (2)
   output logic [183:0] rsp_tdata,
   // hit
   output logic         rsp_tuser
);
   import bsc_pkg::*;

   bsc_req_type   req;
   logic          en;
   logic          fr_v, sq_v, dv_v;
   logic [SQW-1:0] fr_sum;
   bsc_side_type  fr_side, sq_side;
   logic [CW:0]   sq_len;
   bsc_rsp_type   dv_rsp;

   logic [1:0]    count_ff, count_in;
   bsc_rsp_type   slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic          push, pop;

   // Unpack the request
   assign req.box_x      = req_tdata[31:0];
   assign req.box_y      = req_tdata[63:32];
   assign req.box_z      = req_tdata[95:64];
   assign req.box_width  = req_tdata[127:96];
   assign req.box_height = req_tdata[159:128];
   assign req.box_depth  = req_tdata[191:160];
   assign req.sphere_x   = req_tdata[223:192];
   assign req.sphere_y   = req_tdata[255:224];
   assign req.sphere_z   = req_tdata[287:256];
   assign req.radius     = req_tdata[318:288];

   // Advance the whole pipeline unless both output slots are taken
   assign en         = (count_ff != 2'd2);
   assign req_tready = en;

   bsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_req    (req),
      .out_valid (fr_v),
      .out_sum   (fr_sum),
      .out_side  (fr_side)
   );

   bsc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fr_v),
      .in_rad    (fr_sum),
      .in_side   (fr_side),
      .out_valid (sq_v),
      .out_len   (sq_len),
      .out_side  (sq_side)
   );

   bsc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_v),
      .in_len    (sq_len),
      .in_side   (sq_side),
      .out_valid (dv_v),
      .out_rsp   (dv_rsp)
   );

   // Output buffer: slot0 is presented, slot1 holds an overflow response
   assign push = en && dv_v;
   assign pop  = rsp_tvalid && rsp_tready;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               slot0_in = dv_rsp;
            end else begin
               slot1_in = dv_rsp;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            slot0_in = dv_rsp;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tuser  = slot0_ff.hit;
   assign rsp_tdata  = {2'b00, slot0_ff.point_z, slot0_ff.point_y, slot0_ff.point_x,
                        slot0_ff.depth, slot0_ff.normal_z, slot0_ff.normal_y,
                        slot0_ff.normal_x};

   // Checks
   `BSC_ASSERT_NOW(a_miss_is_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "miss response carries a nonzero payload")
   `BSC_ASSERT_NOW(a_take_while_wait, clock, reset, rsp_tvalid && !rsp_tready && count_ff == 2'd1, req_tready, "request blocked by a single waiting response")
   `BSC_ASSERT_NEXT(a_stall_keeps_item, clock, reset, dv_v && !en, dv_v, "stalled pipeline lost its last item")
   `BSC_ASSERT_NOW(a_normal_range, clock, reset, rsp_tvalid && rsp_tuser, slot0_ff.normal_x <= NORM_ONE && slot0_ff.normal_x >= -NORM_ONE, "normal component beyond one unit")

endmodule
